@@ rtl/sps_pkg.sv @@
// Shared types and constants for the support point search block.
// No dependencies.
package sps_pkg;

  localparam int CFG_W = 7;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_DROP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  // flags riding along the projection pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

endpackage

@@ rtl/sps_front.sv @@
// Front end: accepts requests, decodes them and buffers them in a two-entry queue.
// Depends on sps_pkg.
module sps_front #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16,
  parameter int SLOT_W       = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic [3*COORD_BITS-1:0] in_vec,
  output sps_pkg::q_head_t        head,
  output logic [SLOT_W-1:0]       head_slot,
  output logic [3*COORD_BITS-1:0] head_vec,
  input  logic                    pop
);

  sps_pkg::op_t            e_op   [2];
  logic [SLOT_W-1:0]       e_slot [2];
  logic [3*COORD_BITS-1:0] e_vec  [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;
  sps_pkg::op_t            op_in;
  logic                    push;
  logic                    do_pop;

  always_comb begin
    if (in_kind == sps_pkg::KIND_QUERY) begin
      op_in = sps_pkg::OP_QUERY;
    end else if ({1'b0, in_slot} < (SLOT_W + 1)'(MAX_VERTICES)) begin
      op_in = sps_pkg::OP_LOAD;
    end else begin
      op_in = sps_pkg::OP_DROP;
    end
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.op    = e_op[rd_ptr];
  assign head_slot  = e_slot[rd_ptr];
  assign head_vec   = e_vec[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      e_op[wr_ptr]   <= op_in;
      e_slot[wr_ptr] <= in_slot;
      e_vec[wr_ptr]  <= in_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/sps_proj.sv @@
// Projection pipeline: three products in one stage, their exact sum in the next.
// Depends on sps_pkg.
module sps_proj #(
  parameter int COORD_BITS = 16,
  parameter int SLOT_W     = 6,
  parameter int PW         = 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3*COORD_BITS-1:0] dir,
  input  sps_pkg::pipe_ctl_t      in_ctl,
  input  logic [SLOT_W-1:0]       in_idx,
  input  logic [3*COORD_BITS-1:0] in_vert,
  output sps_pkg::pipe_ctl_t      out_ctl,
  output logic [SLOT_W-1:0]       out_idx,
  output logic [3*COORD_BITS-1:0] out_vert,
  output logic signed [PW-1:0]    out_sum
);

  logic signed [COORD_BITS-1:0]   d    [3];
  logic signed [COORD_BITS-1:0]   v    [3];
  logic signed [2*COORD_BITS-1:0] prod [3];
  sps_pkg::pipe_ctl_t             a_ctl;
  logic [SLOT_W-1:0]              a_idx;
  logic [3*COORD_BITS-1:0]        a_vert;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = dir[i*COORD_BITS +: COORD_BITS];
      v[i] = in_vert[i*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= d[i] * v[i];
    end
    a_idx    <= in_idx;
    a_vert   <= in_vert;
    out_sum  <= PW'(prod[0]) + PW'(prod[1]) + PW'(prod[2]);
    out_idx  <= a_idx;
    out_vert <= a_vert;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      out_ctl <= '0;
    end else begin
      a_ctl   <= in_ctl;
      out_ctl <= a_ctl;
    end
  end

endmodule

@@ rtl/sps_back.sv @@
// Back end: vertex memory, query sequencer, running maximum and result register.
// Depends on sps_pkg and sps_proj.
module sps_back #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16,
  parameter int SLOT_W       = 6,
  parameter int PW           = 34
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sps_pkg::CFG_W-1:0]  vertex_count,
  input  sps_pkg::q_head_t           head,
  input  logic [SLOT_W-1:0]          head_slot,
  input  logic [3*COORD_BITS-1:0]    head_vec,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SLOT_W-1:0]          out_idx,
  output logic [3*COORD_BITS-1:0]    out_vert,
  output logic [PW-1:0]              out_proj
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CW    = (sps_pkg::CFG_W > CNT_W) ? sps_pkg::CFG_W : CNT_W;

  sps_pkg::state_t         state;
  sps_pkg::state_t         state_next;
  logic [3*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic [3*COORD_BITS-1:0] dir;
  logic [SLOT_W-1:0]       rd_addr;
  logic [SLOT_W-1:0]       last_idx;
  logic [CW-1:0]           cnt_ext;
  logic [CW-1:0]           n_eff;
  logic                    mem_we;
  logic                    mem_re;
  logic                    start;
  logic                    issue_last;
  logic                    out_load;
  sps_pkg::pipe_ctl_t      s1_ctl;
  logic [SLOT_W-1:0]       s1_idx;
  logic [3*COORD_BITS-1:0] s1_vert;
  sps_pkg::pipe_ctl_t      p_ctl;
  logic [SLOT_W-1:0]       p_idx;
  logic [3*COORD_BITS-1:0] p_vert;
  logic signed [PW-1:0]    p_sum;
  logic signed [PW-1:0]    best_proj;
  logic [SLOT_W-1:0]       best_idx;
  logic [3*COORD_BITS-1:0] best_vert;
  logic                    take;

  // zero searches one entry, anything past the table is clipped
  always_comb begin
    cnt_ext = CW'(vertex_count);
    if (cnt_ext == '0) begin
      n_eff = CW'(1);
    end else if (cnt_ext > CW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = cnt_ext;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sps_pkg::ST_IDLE: begin
        if (head.valid && head.op == sps_pkg::OP_QUERY) begin
          state_next = sps_pkg::ST_ISSUE;
        end
      end
      sps_pkg::ST_ISSUE: begin
        if (rd_addr == last_idx) begin
          state_next = sps_pkg::ST_DRAIN;
        end
      end
      sps_pkg::ST_DRAIN: begin
        if (p_ctl.valid && p_ctl.last) begin
          state_next = sps_pkg::ST_DONE;
        end
      end
      sps_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = sps_pkg::ST_IDLE;
        end
      end
      default: state_next = sps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    start      = 1'b0;
    issue_last = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      sps_pkg::ST_IDLE: begin
        pop    = head.valid;
        mem_we = head.valid && head.op == sps_pkg::OP_LOAD;
        start  = head.valid && head.op == sps_pkg::OP_QUERY;
      end
      sps_pkg::ST_ISSUE: begin
        mem_re     = 1'b1;
        issue_last = (rd_addr == last_idx);
      end
      sps_pkg::ST_DRAIN: begin
      end
      sps_pkg::ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head_slot] <= head_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      s1_vert <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dir      <= head_vec;
      rd_addr  <= '0;
      last_idx <= SLOT_W'(n_eff - CW'(1));
    end else if (mem_re) begin
      rd_addr <= rd_addr + SLOT_W'(1);
    end
    s1_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sps_pkg::ST_IDLE;
      s1_ctl <= '0;
    end else begin
      state      <= state_next;
      s1_ctl.valid <= mem_re;
      s1_ctl.last  <= issue_last;
    end
  end

  sps_proj #(
    .COORD_BITS (COORD_BITS),
    .SLOT_W     (SLOT_W),
    .PW         (PW)
  ) u_proj (
    .clk      (clk),
    .rst      (rst),
    .dir      (dir),
    .in_ctl   (s1_ctl),
    .in_idx   (s1_idx),
    .in_vert  (s1_vert),
    .out_ctl  (p_ctl),
    .out_idx  (p_idx),
    .out_vert (p_vert),
    .out_sum  (p_sum)
  );

  // entry 0 seeds the maximum; ties keep the earlier entry
  assign take = p_ctl.valid && ((p_idx == '0) || (p_sum > best_proj));

  always_ff @(posedge clk) begin
    if (take) begin
      best_proj <= p_sum;
      best_idx  <= p_idx;
      best_vert <= p_vert;
    end
    if (out_load) begin
      out_idx  <= best_idx;
      out_vert <= best_vert;
      out_proj <= best_proj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/support_point_search.sv @@
// Top level of the support point search block: config register, front end, back end.
// Depends on sps_pkg, sps_front, sps_back.
//
//   channel  dir  handshake          payload
//   cfg      in   cfg_we             cfg_wdata = vertex_count
//   s_*      in   s_tvalid/s_tready  tuser = kind; tdata = slot, x, y, z
//   m_*      out  m_tvalid/m_tready  tdata = index, x, y, z, projection
//
// A load is written to the vertex memory straight from the queue head; a query reads
// the entries through the single read port of the vertex memory (one entry per cycle).
// Two requests queue in front of the back end and the result has its own register,
// so the back end moves on while a result waits on m_tready; input stalls once the
// queue is full. Reset is synchronous; vertex_count resets to 1 and the
// vertex memory is not cleared.
module support_point_search #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sps_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // vertex_slot, vec_x, vec_y, vec_z, zero pad
  input  logic [(($clog2(MAX_VERTICES) + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // kind
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // support_index, support_x, support_y, support_z, max_projection, zero pad
  output logic [(($clog2(MAX_VERTICES) + 5 * COORD_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int SLOT_W = $clog2(MAX_VERTICES);
  localparam int PW     = 2 * COORD_BITS + 2;
  localparam int IN_W   = SLOT_W + 3 * COORD_BITS;
  localparam int OUT_W  = SLOT_W + 3 * COORD_BITS + PW;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  logic [sps_pkg::CFG_W-1:0] vertex_count;
  sps_pkg::q_head_t          head;
  logic [SLOT_W-1:0]         head_slot;
  logic [3*COORD_BITS-1:0]   head_vec;
  logic                      pop;
  logic [SLOT_W-1:0]         res_idx;
  logic [3*COORD_BITS-1:0]   res_vert;
  logic [PW-1:0]             res_proj;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= sps_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  sps_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .SLOT_W       (SLOT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_slot   (s_tdata[SLOT_W-1:0]),
    .in_vec    (s_tdata[IN_W-1:SLOT_W]),
    .head      (head),
    .head_slot (head_slot),
    .head_vec  (head_vec),
    .pop       (pop)
  );

  sps_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .SLOT_W       (SLOT_W),
    .PW           (PW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .head         (head),
    .head_slot    (head_slot),
    .head_vec     (head_vec),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_idx      (res_idx),
    .out_vert     (res_vert),
    .out_proj     (res_proj)
  );

  assign m_tdata = OUT_TW'({res_proj, res_vert, res_idx});

endmodule
